/* rtl/core/efcd_pkg.sv */
// Package with the constants, types and helper functions of the event flag claim dispatch block.
`default_nettype none

package efcd_pkg;

   localparam int EVENT_COUNT = 128;
   localparam int CORE_COUNT  = 2;
   localparam int WORD_BITS   = 32;
   localparam int WORD_SHIFT  = $clog2(WORD_BITS);
   localparam int BLOCKS      = (EVENT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int BLOCK_BITS  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CORE_BITS   = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

   localparam int OP_W     = 3;
   localparam int CORE_W   = 1;
   localparam int EVENT_W  = 8;
   localparam int BLKIDX_W = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_CLAIM    = 3'd0,
      OP_UNCLAIM  = 3'd1,
      OP_SET      = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_CAN_WAIT = 3'd4,
      OP_DISPATCH = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CLAIMED = 2'd1,
      STATUS_NONE    = 2'd2
   } status_type;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic                 yield_enabled;
      logic [BLKIDX_W-1:0]  block_index;
      logic [EVENT_W-1:0]   event_in;
      logic [CORE_W-1:0]    core;
      logic [OP_W-1:0]      op;
   } req_type;

   typedef struct packed {
      word_type             active_word;
      logic                 ok_flag;
      logic [EVENT_W-1:0]   event_out;
      logic [STATUS_W-1:0]  status;
   } rsp_type;

   // Bits of a block that name real events; only a partial last block is masked.
   function automatic word_type block_mask(input int blk);
      int left;
      begin
         left = EVENT_COUNT - blk * WORD_BITS;
         if (left >= WORD_BITS) begin
            block_mask = '1;
         end else begin
            block_mask = (word_type'(1) << left) - word_type'(1);
         end
      end
   endfunction

   function automatic word_type lowest_onehot(input word_type bits);
      begin
         lowest_onehot = bits & (~bits + word_type'(1));
      end
   endfunction

   function automatic logic [WORD_SHIFT-1:0] onehot_index(input word_type onehot);
      logic [WORD_SHIFT-1:0] idx;
      begin
         idx = '0;
         for (int i = 0; i < WORD_BITS; i++) begin
            if (onehot[i]) begin
               idx = idx | WORD_SHIFT'(i);
            end
         end
         onehot_index = idx;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/core/event_flag_claim_dispatch.sv */
// Event flag claim dispatch: pending and per-core claim bitmaps with one request per cycle.
// A request accepted into the request register moves its response into the response register
// once that register is empty or being taken.
// Throughput: one request per cycle while the response is not stalled; the whole update and the
// 128-bit lowest-free search sit between the request register and the response register.
// A stalled response holds the request register; new requests are still taken while it is empty.
// Reset clears both bitmaps and both stages at once, with no clearing pass.
`default_nettype none

module event_flag_claim_dispatch (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // op [2:0], core [3], event_in [11:4], block_index [13:12], yield_enabled [14]
   input  wire  [efcd_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // status [1:0], event_out [9:2], ok_flag [10], active_word [42:11]
   output logic [efcd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int REQ_BITS = $bits(efcd_pkg::req_type);

   logic                  in_valid_ff;
   efcd_pkg::req_type     in_data_ff;
   logic                  out_valid_ff;
   efcd_pkg::rsp_type     out_data_ff;
   efcd_pkg::rsp_type     out_data_in;
   logic                  advance;

   efcd_pkg::word_type    pending_ff [efcd_pkg::BLOCKS];
   efcd_pkg::word_type    pending_in [efcd_pkg::BLOCKS];
   efcd_pkg::word_type    claim_ff   [efcd_pkg::CORE_COUNT][efcd_pkg::BLOCKS];
   efcd_pkg::word_type    claim_in   [efcd_pkg::CORE_COUNT][efcd_pkg::BLOCKS];
   efcd_pkg::word_type    free_bits  [efcd_pkg::BLOCKS];

   logic                                  ev_valid;
   logic [efcd_pkg::BLOCK_BITS-1:0]       ev_blk;
   efcd_pkg::word_type                    ev_bit;
   logic [efcd_pkg::CORE_BITS-1:0]        core_sel;
   logic                                  found;
   logic [efcd_pkg::BLOCK_BITS-1:0]       found_blk;
   efcd_pkg::word_type                    found_onehot;
   logic [efcd_pkg::WORD_SHIFT-1:0]       found_idx;
   efcd_pkg::word_type                    held;
   efcd_pkg::word_type                    claim_mask;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = efcd_pkg::RSP_DATA_W'(out_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= efcd_pkg::req_type'(req_tdata[REQ_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < efcd_pkg::BLOCKS; b++) begin
            pending_ff[b] <= '0;
            for (int c = 0; c < efcd_pkg::CORE_COUNT; c++) begin
               claim_ff[c][b] <= '0;
            end
         end
      end else if (advance) begin
         for (int b = 0; b < efcd_pkg::BLOCKS; b++) begin
            pending_ff[b] <= pending_in[b];
            for (int c = 0; c < efcd_pkg::CORE_COUNT; c++) begin
               claim_ff[c][b] <= claim_in[c][b];
            end
         end
      end
   end

   always_comb begin
      ev_valid = int'(in_data_ff.event_in) < efcd_pkg::EVENT_COUNT;
      ev_blk   = ev_valid
               ? efcd_pkg::BLOCK_BITS'(in_data_ff.event_in >> efcd_pkg::WORD_SHIFT)
               : '0;
      ev_bit   = efcd_pkg::word_type'(1)
               << in_data_ff.event_in[efcd_pkg::WORD_SHIFT-1:0];
      core_sel = (int'(in_data_ff.core) < efcd_pkg::CORE_COUNT)
               ? efcd_pkg::CORE_BITS'(in_data_ff.core) : '0;
   end

   always_comb begin
      for (int b = 0; b < efcd_pkg::BLOCKS; b++) begin
         held = '0;
         for (int c = 0; c < efcd_pkg::CORE_COUNT; c++) begin
            held = held | claim_ff[c][b];
         end
         free_bits[b] = ~held & efcd_pkg::block_mask(b);
      end
      found     = 1'b0;
      found_blk = '0;
      for (int b = 0; b < efcd_pkg::BLOCKS; b++) begin
         if (!found && (free_bits[b] != '0)) begin
            found     = 1'b1;
            found_blk = efcd_pkg::BLOCK_BITS'(b);
         end
      end
      found_onehot = efcd_pkg::lowest_onehot(free_bits[found_blk]);
      found_idx    = efcd_pkg::onehot_index(found_onehot);
   end

   always_comb begin
      pending_in  = pending_ff;
      claim_in    = claim_ff;
      claim_mask  = '0;
      out_data_in.status      = efcd_pkg::STATUS_OK;
      out_data_in.event_out   = in_data_ff.event_in;
      out_data_in.ok_flag     = 1'b0;
      out_data_in.active_word = '0;
      unique case (in_data_ff.op)
         efcd_pkg::OP_CLAIM: begin
            if (ev_valid) begin
               out_data_in.status = efcd_pkg::STATUS_CLAIMED;
            end else if (!found) begin
               out_data_in.status = efcd_pkg::STATUS_NONE;
            end else begin
               pending_in[found_blk] = pending_ff[found_blk] & ~found_onehot;
               claim_in[core_sel][found_blk] = claim_ff[core_sel][found_blk] | found_onehot;
               out_data_in.event_out = efcd_pkg::EVENT_W'(
                  int'(found_blk) * efcd_pkg::WORD_BITS + int'(found_idx));
            end
         end
         efcd_pkg::OP_UNCLAIM: begin
            if (ev_valid && ((claim_ff[core_sel][ev_blk] & ev_bit) != '0)) begin
               claim_in[core_sel][ev_blk] = claim_ff[core_sel][ev_blk] & ~ev_bit;
               out_data_in.event_out = efcd_pkg::EVENT_W'(efcd_pkg::EVENT_COUNT);
               out_data_in.ok_flag   = 1'b1;
            end
         end
         efcd_pkg::OP_SET: begin
            if (ev_valid) begin
               pending_in[ev_blk] = pending_ff[ev_blk] | ev_bit;
            end
         end
         efcd_pkg::OP_CLEAR: begin
            if (ev_valid) begin
               pending_in[ev_blk] = pending_ff[ev_blk] & ~ev_bit;
            end
         end
         efcd_pkg::OP_CAN_WAIT: begin
            out_data_in.ok_flag = in_data_ff.yield_enabled && ev_valid
                               && ((claim_ff[core_sel][ev_blk] & ev_bit) != '0);
         end
         efcd_pkg::OP_DISPATCH: begin
            if (int'(in_data_ff.block_index) < efcd_pkg::BLOCKS) begin
               claim_mask = claim_ff[core_sel][efcd_pkg::BLOCK_BITS'(in_data_ff.block_index)];
               out_data_in.active_word =
                  pending_ff[efcd_pkg::BLOCK_BITS'(in_data_ff.block_index)] & claim_mask;
               pending_in[efcd_pkg::BLOCK_BITS'(in_data_ff.block_index)] =
                  pending_ff[efcd_pkg::BLOCK_BITS'(in_data_ff.block_index)] & ~claim_mask;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/efcd_checker.sv */
// Port checker for the event flag claim dispatch block and its bind statement.
`default_nettype none

module efcd_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire [efcd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [efcd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("Stalled response changed its payload.");

   // With no response waiting, the request side is always open.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Request refused while the response stage was empty.");

   // A failed claim carries neither a flag nor an active word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != 2'd0) |-> (rsp_tdata[42:10] == 33'd0))
      else $error("Failed claim returned a flag or an active word.");

   // A released or waitable event never comes with an active word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> (rsp_tdata[42:11] == 32'd0)
                                      && (rsp_tdata[1:0] == 2'd0))
      else $error("Response with ok flag also carried other results.");

   // Nothing is shown in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid right after reset.");

endmodule

bind event_flag_claim_dispatch efcd_checker u_efcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench that drives random and directed requests into the event flag block.

module tb_top;
   import efcd_pkg::*;

   localparam logic [OP_W-1:0]    OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0]    OP_SPARE_HI = 3'd7;
   localparam logic [EVENT_W-1:0] EVENT_UNSET = EVENT_W'(EVENT_COUNT);
   localparam int                 CYCLE_LIMIT = 600000;
   localparam int                 DRAIN_CYCLES = 8;

   // Tracks both bitmaps and the responses still owed by the block.
   class flag_scoreboard;
      word_type pending_word [BLOCKS];
      word_type claim_word [CORE_COUNT][BLOCKS];
      rsp_type  owed_q[$];
      int       errors;

      function new();
         for (int b = 0; b < BLOCKS; b++) begin
            pending_word[b] = '0;
            for (int c = 0; c < CORE_COUNT; c++) begin
               claim_word[c][b] = '0;
            end
         end
         errors = 0;
      endfunction

      function void note_request(input req_type item);
         rsp_type e;
         int      c, ev, b, bit_i, id;
         logic    valid, found, taken;
         e = '0;
         e.event_out = item.event_in;
         ev = item.event_in;
         c = (item.core < CORE_COUNT) ? item.core : 0;
         valid = ev < EVENT_COUNT;
         b = valid ? ev / WORD_BITS : 0;
         bit_i = ev % WORD_BITS;
         case (item.op)
            OP_CLAIM: begin
               if (valid) begin
                  e.status = STATUS_CLAIMED;
               end else begin
                  e.status = STATUS_NONE;
                  found = 1'b0;
                  for (id = 0; id < EVENT_COUNT && !found; id++) begin
                     taken = 1'b0;
                     for (int k = 0; k < CORE_COUNT; k++) begin
                        taken = taken | claim_word[k][id / WORD_BITS][id % WORD_BITS];
                     end
                     if (!taken) begin
                        found = 1'b1;
                        pending_word[id / WORD_BITS][id % WORD_BITS] = 1'b0;
                        claim_word[c][id / WORD_BITS][id % WORD_BITS] = 1'b1;
                        e.event_out = EVENT_W'(id);
                        e.status = STATUS_OK;
                     end
                  end
               end
            end
            OP_UNCLAIM: begin
               if (valid && claim_word[c][b][bit_i]) begin
                  claim_word[c][b][bit_i] = 1'b0;
                  e.event_out = EVENT_UNSET;
                  e.ok_flag = 1'b1;
               end
            end
            OP_SET: begin
               if (valid) pending_word[b][bit_i] = 1'b1;
            end
            OP_CLEAR: begin
               if (valid) pending_word[b][bit_i] = 1'b0;
            end
            OP_CAN_WAIT: begin
               e.ok_flag = item.yield_enabled && valid && claim_word[c][b][bit_i];
            end
            OP_DISPATCH: begin
               if (item.block_index < BLOCKS) begin
                  e.active_word = pending_word[item.block_index] &
                                  claim_word[c][item.block_index];
                  pending_word[item.block_index] = pending_word[item.block_index] &
                                                   ~claim_word[c][item.block_index];
               end
            end
            default: begin
            end
         endcase
         owed_q.push_back(e);
      endfunction

      task report(input string what);
         $display("%0t ns: mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_response(input rsp_type got);
         rsp_type e;
         if (owed_q.size() == 0) begin
            report($sformatf("response %h arrived with no request outstanding", got));
         end else begin
            e = owed_q.pop_front();
            if (got.status !== e.status)
               report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.event_out !== e.event_out)
               report($sformatf("event_out %0d, expected %0d", got.event_out, e.event_out));
            if (got.ok_flag !== e.ok_flag)
               report($sformatf("ok_flag %b, expected %b", got.ok_flag, e.ok_flag));
            if (got.active_word !== e.active_word)
               report($sformatf("active_word %h, expected %h",
                                got.active_word, e.active_word));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;

   flag_scoreboard sb = new();
   int             cycle_count = 0;
   int             stall_left = 0;
   bit             quiet_phase = 1'b0;

   event_flag_claim_dispatch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_length();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Prefers an event that the core already holds, so that releases and waits succeed often.
   function automatic logic [EVENT_W-1:0] held_event(input int core);
      int id;
      id = 0;
      for (int t = 0; t < 16; t++) begin
         id = $urandom_range(0, EVENT_COUNT - 1);
         if (sb.claim_word[core][id / WORD_BITS][id % WORD_BITS]) return EVENT_W'(id);
      end
      return EVENT_W'(id);
   endfunction

   function automatic req_type random_request(input int claim_pct, input int unclaim_pct);
      req_type item;
      int      r;
      r = $urandom_range(0, 99);
      item.core = CORE_W'($urandom_range(0, 1));
      item.block_index = BLKIDX_W'($urandom);
      item.yield_enabled = ($urandom_range(0, 4) != 0);
      item.event_in = EVENT_W'($urandom_range(0, EVENT_COUNT - 1));
      if (r < claim_pct) begin
         item.op = OP_CLAIM;
         if ($urandom_range(0, 99) < 85) item.event_in = EVENT_UNSET;
         else item.event_in = EVENT_W'($urandom);
      end else if (r < claim_pct + unclaim_pct) begin
         item.op = OP_UNCLAIM;
         if ($urandom_range(0, 2) != 0) item.event_in = held_event(item.core);
      end else begin
         case ($urandom_range(0, 8))
            0:       item.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
            1, 2:    item.op = OP_SET;
            3:       item.op = OP_CLEAR;
            4, 5:    item.op = OP_CAN_WAIT;
            default: item.op = OP_DISPATCH;
         endcase
         if (item.op == OP_CAN_WAIT && $urandom_range(0, 1) != 0)
            item.event_in = held_event(item.core);
      end
      if (item.op != OP_CLAIM && $urandom_range(0, 9) == 0)
         item.event_in = EVENT_W'($urandom_range(EVENT_COUNT, 255));
      return item;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(item);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(item);
      gap = idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= REQ_DATA_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input int core, input int ev,
                          input int blk, input bit yld);
      req_type item;
      item.op = op;
      item.core = CORE_W'(core);
      item.event_in = EVENT_W'(ev);
      item.block_index = BLKIDX_W'(blk);
      item.yield_enabled = yld;
      send_request(item);
   endtask

   task automatic run_phase(input int claim_pct, input int unclaim_pct, input int count,
                            input bit quiet);
      quiet_phase = quiet;
      repeat (count) send_request(random_request(claim_pct, unclaim_pct));
      quiet_phase = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= idle_length();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]));
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_op(OP_SET, 0, 0, 3, 1'b0);
      send_op(OP_SET, 1, EVENT_COUNT - 1, 0, 1'b1);
      send_op(OP_SET, 0, 255, 2, 1'b0);
      send_op(OP_CLAIM, 0, EVENT_COUNT, 1, 1'b1);
      send_op(OP_CLAIM, 1, EVENT_COUNT, 2, 1'b0);
      send_op(OP_CLAIM, 0, 5, 0, 1'b1);
      send_op(OP_CLAIM, 0, 200, 3, 1'b1);
      send_op(OP_CAN_WAIT, 0, 0, 0, 1'b1);
      send_op(OP_CAN_WAIT, 0, 0, 1, 1'b0);
      send_op(OP_CAN_WAIT, 1, 0, 2, 1'b1);
      send_op(OP_CAN_WAIT, 0, 255, 3, 1'b1);
      send_op(OP_SET, 0, 2, 0, 1'b0);
      send_op(OP_SET, 1, 1, 0, 1'b1);
      send_op(OP_DISPATCH, 0, 0, 0, 1'b1);
      send_op(OP_DISPATCH, 1, 255, 0, 1'b0);
      send_op(OP_DISPATCH, 0, 0, 3, 1'b1);
      send_op(OP_CLEAR, 1, EVENT_COUNT - 1, 1, 1'b0);
      send_op(OP_CLEAR, 0, EVENT_COUNT, 2, 1'b1);
      send_op(OP_UNCLAIM, 1, 0, 3, 1'b1);
      send_op(OP_UNCLAIM, 0, 0, 0, 1'b0);
      send_op(OP_UNCLAIM, 0, 255, 1, 1'b1);
      send_op(OP_SPARE_LO, 1, 77, 2, 1'b1);
      send_op(OP_SPARE_HI, 0, 255, 3, 1'b1);
      send_op(OP_CLAIM, 1, EVENT_COUNT, 3, 1'b1);
      send_op(OP_DISPATCH, 1, 0, 3, 1'b0);

      run_phase(70, 5, 350, 1'b0);
      run_phase(25, 20, 400, 1'b1);
      run_phase(5, 60, 300, 1'b0);
      run_phase(30, 25, 400, 1'b0);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/efcd_pkg.sv
rtl/core/event_flag_claim_dispatch.sv
rtl/core/efcd_checker.sv
sim/tb_top.sv
